>>> src/assert_macros.svh
// assertion macros for the polyline interpolator
// expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PTI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PTI_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PTI_ASSERT(lbl, prop, msg)
`define PTI_NEVER(lbl, cond, msg)
`endif
`endif

>>> src/pti_pkg.sv
// shared types and constants of the polyline interpolator
// no dependencies
package pti_pkg;

    localparam int COORD_W      = 32;
    localparam int ROOT_W       = 33;
    localparam int RAD_W        = 2 * ROOT_W;
    localparam int SEG_LEN_W    = 40;
    localparam int TOTAL_W      = 48;
    localparam int NUM_W        = 81;
    localparam int DEN_W        = TOTAL_W + 16;
    localparam int DEF_MAX_POINTS = 256;
    localparam int DEF_MAX_STEPS  = 64;

    localparam logic [31:0] RST_SEG_TIME = 32'd65536;
    localparam logic [15:0] RST_APS      = 16'd60;

    localparam logic REG_SEG_TIME = 1'b0;
    localparam logic REG_APS      = 1'b1;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic [2:0] ST_POINT    = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_FINAL    = 3'd2;
    localparam logic [2:0] ST_ACCEPTED = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_NONE     = 3'd5;

    typedef struct packed {
        logic                       opcode;
        logic signed [COORD_W-1:0]  x_coord;
        logic signed [COORD_W-1:0]  y_coord;
        logic signed [COORD_W-1:0]  z_coord;
    } cmd_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]  out_x;
        logic signed [COORD_W-1:0]  out_y;
        logic signed [COORD_W-1:0]  out_z;
        logic [2:0]                 status;
        logic                       last;
    } res_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
    } point_t;

endpackage

>>> src/pti_store.sv
// point store and segment length store, one write and one registered read each
// depends on pti_pkg
module pti_store
    import pti_pkg::*;
#(
    parameter int IDX_W = 8
)(
    input  logic                 clk,
    input  logic                 pt_wr_en,
    input  logic [IDX_W-1:0]     pt_wr_addr,
    input  point_t               pt_wr_data,
    input  logic                 len_wr_en,
    input  logic [IDX_W-1:0]     len_wr_addr,
    input  logic [SEG_LEN_W-1:0] len_wr_data,
    input  logic [IDX_W-1:0]     rd_addr,
    output point_t               rd_point,
    output logic [SEG_LEN_W-1:0] rd_len
);

    localparam int DEPTH = 1 << IDX_W;

    point_t               pt_mem  [DEPTH];
    logic [SEG_LEN_W-1:0] len_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (pt_wr_en)
        begin
            pt_mem[pt_wr_addr] <= pt_wr_data;
        end
        rd_point <= pt_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (len_wr_en)
        begin
            len_mem[len_wr_addr] <= len_wr_data;
        end
        rd_len <= len_mem[rd_addr];
    end

endmodule

>>> src/pti_sqrt.sv
// iterative integer square root, two radicand bits per cycle
// depends on pti_pkg
module pti_sqrt
    import pti_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int REM_W  = ROOT_W + 3;
    localparam int ITER_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ITER_W-1:0] iter_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    always_comb
    begin
        rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                iter_reg <= '0;
            end
            else if (busy_reg)
            begin
                rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], ge};
                iter_reg <= iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> src/pti_div.sv
// iterative unsigned divider, one quotient bit per cycle
// depends on pti_pkg
module pti_div
    import pti_pkg::*;
#(
    parameter int DIV_W = 7
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [COORD_W-1:0] dividend,
    input  logic [DIV_W-1:0]   divisor,
    output logic               done,
    output logic [COORD_W-1:0] quotient
);

    localparam int ITER_W = $clog2(COORD_W + 1);

    logic [COORD_W-1:0] dvd_reg;
    logic [DIV_W-1:0]   dvs_reg;
    logic [DIV_W-1:0]   rem_reg;
    logic [ITER_W-1:0]  iter_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [DIV_W:0]     rem_sh;
    logic [DIV_W:0]     rem_sub;
    logic               ge;

    always_comb
    begin
        rem_sh  = {rem_reg, dvd_reg[COORD_W-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        ge      = (rem_sh >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                dvd_reg  <= dividend;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
                iter_reg <= '0;
            end
            else if (busy_reg)
            begin
                // quotient bits shift in where the dividend bits leave
                dvd_reg  <= {dvd_reg[COORD_W-2:0], ge};
                rem_reg  <= ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
                iter_reg <= iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(COORD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

>>> src/polyline_time_interpolator_core.sv
// top level of the polyline interpolator: sequencer, shared multiplier, apb registers
// depends on pti_pkg, pti_store, pti_sqrt, pti_div, assert_macros.svh
//
// channel | signals                     | moves
// cmd     | cmd_valid cmd_ready cmd     | one add or step command per transaction
// res     | res_valid res_ready res     | one result point or status per transaction
// apb     | psel penable pwrite paddr.. | segment_time at 0, point rate at 4
//
// add: the result waits on the square root unit and its 33 iterations;
// the first point of the store skips the difference and the square root
// step: reads the segment, multiplies, searches the count and runs three divisions
// before the first point, then one point per cycle while res_ready is high
// cmd_ready is high only when no result is pending
// no clearing pass after reset; a stalled res holds the sequencer
`include "assert_macros.svh"

module polyline_time_interpolator_core
    import pti_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int MAX_STEPS  = DEF_MAX_STEPS
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int STEP_W = $clog2(MAX_STEPS + 1);
    localparam int CMP_W  = DEN_W + STEP_W;

    typedef enum logic [4:0] {
        S_IDLE, S_ADIFF, S_SQ, S_SQGO, S_SQRT, S_AWR,
        S_RDB, S_RDC, S_M1, S_M2, S_M3, S_M4, S_M5, S_CNT, S_CEND,
        S_DGO, S_DIV, S_EMIT, S_RES
    } state_t;

    state_t               state_reg;
    logic [31:0]          time_reg;
    logic [15:0]          aps_reg;
    logic [CNT_W-1:0]     point_count_reg;
    logic [CNT_W-1:0]     seg_index_reg;
    logic [TOTAL_W-1:0]   total_reg;
    cmd_t                 cmd_reg;
    point_t               last_pt_reg;
    point_t               start_reg;
    point_t               end_reg;
    logic [ROOT_W-1:0]    len_reg;
    logic [63:0]          prod_reg;
    logic [NUM_W-1:0]     acc_reg;
    logic [47:0]          num_a_reg;
    logic [1:0]           phase_reg;
    logic [CMP_W-1:0]     cmp_reg;
    logic [STEP_W-1:0]    step_cnt_reg;
    logic [STEP_W-1:0]    emit_reg;
    logic [COORD_W-1:0]   absd_reg  [3];
    logic                 neg_reg   [3];
    logic [COORD_W-1:0]   delta_reg [3];
    res_t                 res_reg;
    logic                 res_valid_reg;

    logic [31:0]          mul_a;
    logic [31:0]          mul_b;
    logic [CNT_W-1:0]     seg_inc;
    logic [CNT_W-1:0]     count_dec;
    logic [IDX_W-1:0]     rd_addr;
    point_t               rd_point;
    logic [SEG_LEN_W-1:0] rd_len;
    logic                 pt_wr_en;
    logic                 len_wr_en;
    logic [TOTAL_W:0]     total_sum;
    logic [DEN_W-1:0]     den;
    logic                 sq_start;
    logic                 sq_done;
    logic [ROOT_W-1:0]    sq_root;
    logic                 dv_start;
    logic                 dv_done;
    logic [COORD_W-1:0]   dv_quot;
    logic [COORD_W-1:0]   dv_dividend;
    logic                 cmd_fire;
    logic                 res_fire;
    logic [STEP_W:0]      emit_inc1;
    logic [STEP_W:0]      emit_inc2;

    function automatic logic [COORD_W:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                  input logic signed [COORD_W-1:0] b);
        logic [COORD_W:0] d;
        logic [COORD_W:0] n;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        n = -d;
        return d[COORD_W] ? {1'b1, n[COORD_W-1:0]} : {1'b0, d[COORD_W-1:0]};
    endfunction

    function automatic res_t make_res(input logic [2:0] st, input point_t p, input logic lst);
        res_t r;
        r.out_x  = p.x;
        r.out_y  = p.y;
        r.out_z  = p.z;
        r.status = st;
        r.last   = lst;
        return r;
    endfunction

    assign cmd_fire  = cmd_valid && cmd_ready;
    assign res_fire  = res_valid_reg && res_ready;
    assign seg_inc   = seg_index_reg + CNT_W'(1);
    assign count_dec = point_count_reg - CNT_W'(1);
    assign total_sum = {1'b0, total_reg} + {{(TOTAL_W + 1 - ROOT_W){1'b0}}, len_reg};
    assign den       = {total_reg, 16'h0000};
    assign emit_inc1 = {1'b0, emit_reg} + (STEP_W + 1)'(1);
    assign emit_inc2 = {1'b0, emit_reg} + (STEP_W + 1)'(2);
    assign pt_wr_en  = (state_reg == S_AWR);
    assign len_wr_en = (state_reg == S_AWR) && (point_count_reg != '0);
    assign sq_start  = (state_reg == S_SQGO);
    assign dv_start  = (state_reg == S_DGO);
    assign rd_addr   = (state_reg == S_RDB) ? seg_inc[IDX_W-1:0] : seg_index_reg[IDX_W-1:0];

    always_comb
    begin
        dv_dividend = absd_reg[0];
        if (phase_reg == 2'd1)
        begin
            dv_dividend = absd_reg[1];
        end
        else if (phase_reg == 2'd2)
        begin
            dv_dividend = absd_reg[2];
        end
    end

    // the one multiplier, operands picked by state
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQ:
            begin
                mul_a = dv_dividend;
                mul_b = dv_dividend;
            end
            S_RDC:
            begin
                mul_a = {16'h0000, aps_reg};
                mul_b = time_reg;
            end
            S_M2:
            begin
                mul_a = num_a_reg[31:0];
                mul_b = len_reg[31:0];
            end
            S_M3:
            begin
                mul_a = {16'h0000, num_a_reg[47:32]};
                mul_b = len_reg[31:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    pti_store #(.IDX_W(IDX_W)) u_store (
        .clk         (clk),
        .pt_wr_en    (pt_wr_en),
        .pt_wr_addr  (point_count_reg[IDX_W-1:0]),
        .pt_wr_data  ({cmd_reg.x_coord, cmd_reg.y_coord, cmd_reg.z_coord}),
        .len_wr_en   (len_wr_en),
        .len_wr_addr (count_dec[IDX_W-1:0]),
        .len_wr_data ({{(SEG_LEN_W - ROOT_W){1'b0}}, len_reg}),
        .rd_addr     (rd_addr),
        .rd_point    (rd_point),
        .rd_len      (rd_len)
    );

    pti_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (acc_reg[RAD_W-1:0]),
        .done     (sq_done),
        .root     (sq_root)
    );

    pti_div #(.DIV_W(STEP_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start),
        .dividend (dv_dividend),
        .divisor  (step_cnt_reg),
        .done     (dv_done),
        .quotient (dv_quot)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= RST_SEG_TIME;
            aps_reg  <= RST_APS;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_SEG_TIME)
            begin
                time_reg <= pwdata;
            end
            else
            begin
                aps_reg <= pwdata[15:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_APS) ? {16'h0000, aps_reg} : time_reg;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            point_count_reg <= '0;
            seg_index_reg   <= '0;
            total_reg       <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_fire)
                    begin
                        cmd_reg <= cmd;
                        if (cmd.opcode == OP_ADD)
                        begin
                            if (point_count_reg >= CNT_W'(MAX_POINTS))
                            begin
                                res_reg       <= make_res(ST_FULL, '0, 1'b1);
                                res_valid_reg <= 1'b1;
                                state_reg     <= S_RES;
                            end
                            else if (point_count_reg == '0)
                            begin
                                state_reg <= S_AWR;
                            end
                            else
                            begin
                                state_reg <= S_ADIFF;
                            end
                        end
                        else if (point_count_reg == '0)
                        begin
                            res_reg       <= make_res(ST_NONE, '0, 1'b1);
                            res_valid_reg <= 1'b1;
                            state_reg     <= S_RES;
                        end
                        else if ({1'b0, seg_index_reg} + (CNT_W + 1)'(1) >=
                                 {1'b0, point_count_reg})
                        begin
                            res_reg       <= make_res(ST_FINAL, last_pt_reg, 1'b1);
                            res_valid_reg <= 1'b1;
                            state_reg     <= S_RES;
                        end
                        else if (total_reg == '0)
                        begin
                            seg_index_reg <= seg_inc;
                            res_reg       <= make_res(ST_EMPTY, '0, 1'b1);
                            res_valid_reg <= 1'b1;
                            state_reg     <= S_RES;
                        end
                        else
                        begin
                            state_reg <= S_RDB;
                        end
                    end
                end
                S_ADIFF:
                begin
                    {neg_reg[0], absd_reg[0]} <= abs_diff(cmd_reg.x_coord, last_pt_reg.x);
                    {neg_reg[1], absd_reg[1]} <= abs_diff(cmd_reg.y_coord, last_pt_reg.y);
                    {neg_reg[2], absd_reg[2]} <= abs_diff(cmd_reg.z_coord, last_pt_reg.z);
                    phase_reg <= 2'd0;
                    acc_reg   <= '0;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    // square issued this cycle lands in prod_reg next cycle
                    if (phase_reg != 2'd0)
                    begin
                        acc_reg <= acc_reg + {{(NUM_W - 64){1'b0}}, prod_reg};
                    end
                    phase_reg <= phase_reg + 2'd1;
                    if (phase_reg == 2'd3)
                    begin
                        state_reg <= S_SQGO;
                    end
                end
                S_SQGO:
                begin
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (sq_done)
                    begin
                        len_reg   <= sq_root;
                        state_reg <= S_AWR;
                    end
                end
                S_AWR:
                begin
                    if (point_count_reg != '0)
                    begin
                        total_reg <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
                    end
                    point_count_reg <= point_count_reg + CNT_W'(1);
                    last_pt_reg     <= {cmd_reg.x_coord, cmd_reg.y_coord, cmd_reg.z_coord};
                    res_reg         <= make_res(ST_ACCEPTED, '0, 1'b1);
                    res_valid_reg   <= 1'b1;
                    state_reg       <= S_RES;
                end
                S_RDB:
                begin
                    start_reg <= rd_point;
                    len_reg   <= rd_len[ROOT_W-1:0];
                    state_reg <= S_RDC;
                end
                S_RDC:
                begin
                    end_reg   <= rd_point;
                    state_reg <= S_M1;
                end
                S_M1:
                begin
                    num_a_reg <= prod_reg[47:0];
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    acc_reg   <= {{(NUM_W - 64){1'b0}}, prod_reg};
                    state_reg <= S_M4;
                end
                S_M4:
                begin
                    acc_reg   <= acc_reg + ({{(NUM_W - 64){1'b0}}, prod_reg} << 32);
                    state_reg <= S_M5;
                end
                S_M5:
                begin
                    if (len_reg[ROOT_W-1])
                    begin
                        acc_reg <= acc_reg + ({{(NUM_W - 48){1'b0}}, num_a_reg} << 32);
                    end
                    step_cnt_reg <= '0;
                    cmp_reg      <= '0;
                    state_reg    <= S_CNT;
                end
                S_CNT:
                begin
                    // smallest count whose multiple of the scaled total reaches the numerator, capped at MAX_STEPS
                    if ({{(NUM_W - CMP_W){1'b0}}, cmp_reg} >= acc_reg)
                    begin
                        state_reg <= S_CEND;
                    end
                    else if (step_cnt_reg == STEP_W'(MAX_STEPS))
                    begin
                        state_reg <= S_CEND;
                    end
                    else
                    begin
                        step_cnt_reg <= step_cnt_reg + STEP_W'(1);
                        cmp_reg      <= cmp_reg + {{(CMP_W - DEN_W){1'b0}}, den};
                    end
                end
                S_CEND:
                begin
                    seg_index_reg <= seg_inc;
                    if (step_cnt_reg == '0)
                    begin
                        res_reg       <= make_res(ST_EMPTY, '0, 1'b1);
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_RES;
                    end
                    else
                    begin
                        {neg_reg[0], absd_reg[0]} <= abs_diff(end_reg.x, start_reg.x);
                        {neg_reg[1], absd_reg[1]} <= abs_diff(end_reg.y, start_reg.y);
                        {neg_reg[2], absd_reg[2]} <= abs_diff(end_reg.z, start_reg.z);
                        phase_reg <= 2'd0;
                        state_reg <= S_DGO;
                    end
                end
                S_DGO:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (dv_done)
                    begin
                        // truncation toward zero: divide the magnitude, restore the sign
                        if (phase_reg == 2'd0)
                        begin
                            delta_reg[0] <= neg_reg[0] ? -dv_quot : dv_quot;
                        end
                        else if (phase_reg == 2'd1)
                        begin
                            delta_reg[1] <= neg_reg[1] ? -dv_quot : dv_quot;
                        end
                        else
                        begin
                            delta_reg[2] <= neg_reg[2] ? -dv_quot : dv_quot;
                        end
                        if (phase_reg == 2'd2)
                        begin
                            emit_reg      <= '0;
                            res_reg       <= make_res(ST_POINT, start_reg,
                                                      step_cnt_reg == STEP_W'(1));
                            res_valid_reg <= 1'b1;
                            state_reg     <= S_EMIT;
                        end
                        else
                        begin
                            phase_reg <= phase_reg + 2'd1;
                            state_reg <= S_DGO;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (res_fire)
                    begin
                        if (emit_inc1 == {1'b0, step_cnt_reg})
                        begin
                            res_valid_reg <= 1'b0;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            res_reg.out_x <= res_reg.out_x + delta_reg[0];
                            res_reg.out_y <= res_reg.out_y + delta_reg[1];
                            res_reg.out_z <= res_reg.out_z + delta_reg[2];
                            res_reg.last  <= (emit_inc2 == {1'b0, step_cnt_reg});
                            emit_reg      <= emit_inc1[STEP_W-1:0];
                        end
                    end
                end
                S_RES:
                begin
                    if (res_fire)
                    begin
                        res_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `PTI_NEVER(a_ready_while_pending, cmd_ready && res_valid, "command taken with result pending")
    `PTI_ASSERT(a_count_bound, point_count_reg <= CNT_W'(MAX_POINTS), "count over store size")
    `PTI_ASSERT(a_seg_bound, seg_index_reg <= point_count_reg, "segment index past point count")

endmodule
